/* design/bhpq_pkg.sv */
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and defaults for the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // Default geometry
  localparam int DEPTH_DEFAULT     = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;

  // Fixed port widths
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIRST = 1'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  // Configuration seen by the engine
  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             max_first;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

/* design/bhpq_engine.sv */
// ----------------------------------------------------------------------------
// bhpq_engine
// Heap store and sequencer. One shared comparator serves sift-up, the
// child-against-child choice and the child-against-moving-entry test of
// sift-down. The store has one write and one registered read port.
// ----------------------------------------------------------------------------
module bhpq_engine import bhpq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic [OP_W-1:0]   op,
  input  logic [DATA_W-1:0] key_in,
  output logic              ready,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_take
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = IDX_W + 1;
  localparam int WW    = CNT_W + 1;
  localparam int FW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_PEEK, S_P_LAST, S_P_MOV,
    S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_DONE
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic [IDX_W-1:0]     idx;
  logic [KEY_WIDTH-1:0] moving;
  logic [KEY_WIDTH-1:0] best;
  logic [IDX_W-1:0]     best_idx;
  logic [STATUS_W-1:0]  res_status;
  logic [DATA_W-1:0]    res_value;

  // Store
  logic [KEY_WIDTH-1:0] heap_mem [DEPTH];
  logic [KEY_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 mem_we;

  // Shared comparator
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 beats;

  // Address arithmetic
  logic [IDX_W-1:0] parent;
  logic [CW-1:0]    child_w;
  logic [CW-1:0]    right_w;
  logic [IDX_W-1:0] child_l;
  logic             has_right;
  logic             in_loop;
  logic [CAP_W-1:0] cap_eff;
  logic             full;

  assign parent    = (idx - IDX_W'(1)) >> 1;
  assign child_w   = {idx, 1'b1};
  assign right_w   = child_w + CW'(1);
  assign child_l   = child_w[IDX_W-1:0];
  assign has_right = WW'(right_w) < WW'(cnt);
  assign in_loop   = WW'(idx) < WW'(cnt >> 1);

  // Capacity of zero acts as one, anything above the store saturates
  assign cap_eff = (cfg.capacity == '0) ? CAP_W'(1) : cfg.capacity;
  assign full    = (FW'(cnt) >= FW'(cap_eff)) || (FW'(cnt) >= FW'(DEPTH));

  assign beats = cfg.max_first ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  // Store ports and comparator operands per step
  always_comb begin
    rd_addr = '0;
    mem_we  = 1'b0;
    wr_addr = idx;
    wr_data = moving;
    cmp_a   = moving;
    cmp_b   = rd_data;
    unique case (state)
      S_UP_RD: begin
        if (idx == '0) begin
          mem_we = 1'b1;
        end else begin
          rd_addr = parent;
        end
      end
      S_UP_CMP: begin
        mem_we  = 1'b1;
        wr_data = beats ? rd_data : moving;
      end
      S_P_LAST: begin
        rd_addr = IDX_W'(cnt);
      end
      S_DN_RD: begin
        if (in_loop) begin
          rd_addr = child_l;
        end else begin
          mem_we = 1'b1;
        end
      end
      S_DN_L: begin
        rd_addr = right_w[IDX_W-1:0];
      end
      S_DN_R: begin
        cmp_a = rd_data;
        cmp_b = best;
      end
      S_DN_CMP: begin
        cmp_a   = best;
        cmp_b   = moving;
        mem_we  = 1'b1;
        wr_data = beats ? best : moving;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data <= heap_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            res_status <= ST_OK;
            res_value  <= '0;
            state      <= S_DONE;
            case (op)
              OP_OFFER: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  moving <= KEY_WIDTH'(key_in);
                  idx    <= IDX_W'(cnt);
                  cnt    <= cnt + CNT_W'(1);
                  state  <= S_UP_RD;
                end
              end
              OP_POLL: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  cnt   <= cnt - CNT_W'(1);
                  state <= S_P_LAST;
                end
              end
              OP_PEEK: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_PEEK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_UP_RD: begin
          state <= (idx == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (beats) begin
            idx   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_PEEK: begin
          res_value <= DATA_W'(rd_data);
          state     <= S_DONE;
        end
        S_P_LAST: begin
          res_value <= DATA_W'(rd_data);
          state     <= S_P_MOV;
        end
        S_P_MOV: begin
          moving <= rd_data;
          idx    <= '0;
          state  <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= in_loop ? S_DN_L : S_DONE;
        end
        S_DN_L: begin
          best     <= rd_data;
          best_idx <= child_l;
          state    <= has_right ? S_DN_R : S_DN_CMP;
        end
        S_DN_R: begin
          // right child only when strictly better
          if (beats) begin
            best     <= rd_data;
            best_idx <= right_w[IDX_W-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (beats) begin
            idx   <= best_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.value  = res_value;
  assign res.count  = COUNT_W'(cnt);

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");

  a_cnt_only_on_start: assert property (@(posedge clk) disable iff (rst)
    !(state == S_IDLE && start) |=> $stable(cnt))
    else $error("entry count moved outside an accepted transaction");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res_take) |=> state == S_DONE)
    else $error("result dropped before it was taken");

  a_climb_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> idx != '0)
    else $error("sift-up compare at the root");

endmodule

/* design/binary_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Array binary heap priority queue with offer, poll and peek.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_stall is high while it runs. The
// heap store has a single registered read port and every step of sift-up or
// sift-down goes through it and one shared comparator. Full, empty and the
// unused code finish without sifting; peek reads the root; offer writes the
// new entry at the end and climbs while it beats its parent; poll moves the
// last entry to the root and sifts it down, reading the left child, then the
// right child where there is one, and comparing the better child with the
// moving entry. With the output free, the result appears on the output in
// the same cycle as in_stall falls.
// A finished result sits in an output register so the next transaction can
// be accepted while it waits to be taken; a second result that finishes
// while the first still waits holds the input stalled until the first goes.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       operation,
  input  logic [DATA_W-1:0]     key,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [DATA_W-1:0]     value,
  output logic [COUNT_W-1:0]    count
);

  cfg_t cfg;
  logic ready;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic res_take;
  logic start;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= CAPACITY_RESET;
      cfg.max_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:  cfg.capacity  <= cfg_data[CAP_W-1:0];
        CFG_MAX_FIRST: cfg.max_first <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !ready;
  assign start    = in_valid && ready;

  bhpq_engine #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .op        (operation),
    .key_in    (key),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign status = out_res.status;
  assign value  = out_res.value;
  assign count  = out_res.count;

endmodule

/* tb/binary_heap_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_tb
// Self-checking bench for the heap priority queue: a shadow heap predicts
// the status, value and count of every transaction. Runs directed corners,
// then bursty random traffic over several capacity and ordering settings,
// with random output stalls and one long output hold-off to fill the block.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE    = 2'd3;   // unused operation code
  localparam int              CYCLE_LIMIT = 300000;
  localparam int              HOLD_CYCLES = 400;

  // Shadow heap and store of expected replies
  class heap_scoreboard;
    logic [DATA_W-1:0] shadow_heap [DEPTH_DEFAULT];
    int unsigned       held;
    logic [CAP_W-1:0]  cap_reg;
    bit                largest_first;
    res_t              pending_replies [$];
    int unsigned       faults;

    function new();
      held          = 0;
      cap_reg       = CAPACITY_RESET;
      largest_first = 1'b0;
      faults        = 0;
    endfunction

    function bit outranks(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      return largest_first ? (a > b) : (a < b);
    endfunction

    // zero counts as one, anything past the store saturates
    function int unsigned room();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
      return c;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CAPACITY) cap_reg = data;
      else largest_first = data[0];
    endfunction

    // sift-up; equal keys stay below their parent
    function void sift_in(logic [DATA_W-1:0] k);
      int unsigned i;
      int unsigned up;
      i = held;
      held++;
      while (i > 0) begin
        up = (i - 1) >> 1;
        if (!outranks(k, shadow_heap[up])) break;
        shadow_heap[i] = shadow_heap[up];
        i = up;
      end
      shadow_heap[i] = k;
    endfunction

    // last entry moves down from the root; right child only if strictly better
    function logic [DATA_W-1:0] take_root();
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] moving;
      int unsigned       i;
      int unsigned       c;
      int unsigned       half;
      top    = shadow_heap[0];
      held--;
      moving = shadow_heap[held];
      half   = held >> 1;
      i      = 0;
      while (i < half) begin
        c = (i << 1) + 1;
        if (c + 1 < held && outranks(shadow_heap[c + 1], shadow_heap[c])) c++;
        if (!outranks(shadow_heap[c], moving)) break;
        shadow_heap[i] = shadow_heap[c];
        i = c;
      end
      shadow_heap[i] = moving;
      return top;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] k);
      res_t r;
      r.status = ST_OK;
      r.value  = '0;
      case (op)
        OP_OFFER: begin
          if (held >= room()) r.status = ST_FULL;
          else sift_in(k);
        end
        OP_POLL: begin
          if (held == 0) r.status = ST_EMPTY;
          else r.value = take_root();
        end
        OP_PEEK: begin
          if (held == 0) r.status = ST_EMPTY;
          else r.value = shadow_heap[0];
        end
        default: ;
      endcase
      r.count = COUNT_W'(held);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] val,
                              logic [COUNT_W-1:0] cnt);
      res_t exp_r;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected: status %0d value %0h count %0d", st, val, cnt);
        faults++;
        return;
      end
      exp_r = pending_replies.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        faults++;
      end
      if (val !== exp_r.value) begin
        $error("value: expected %0h, got %0h", exp_r.value, val);
        faults++;
      end
      if (cnt !== exp_r.count) begin
        $error("count: expected %0d, got %0d", exp_r.count, cnt);
        faults++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       operation;
  logic [DATA_W-1:0]     key;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [DATA_W-1:0]     value;
  logic [COUNT_W-1:0]    count;

  heap_scoreboard sb = new();
  bit             squeeze_req = 1'b0;
  int             burst_left  = 0;

  binary_heap_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watch both channels at each edge (pre-edge values)
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(operation, key);
      if (out_valid && !out_stall) sb.check_reply(status, value, count);
    end
  end

  // Output stalls: changing modes, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(30, 200);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= ((mode_left % 8) < 3);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until taken
  task automatic present(logic [OP_W-1:0] op, logic [DATA_W-1:0] k);
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every reply is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back while idle
  task automatic configure(logic [CFG_DATA_W-1:0] cap, bit order);
    logic [CFG_DATA_W-1:0] order_word;
    order_word = {6'($urandom), order};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    sb.write_register(CFG_CAPACITY, cap);
    cfg_index <= CFG_MAX_FIRST;
    cfg_data  <= order_word;
    @(posedge clk);
    sb.write_register(CFG_MAX_FIRST, order_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DATA_W'($urandom_range(0, 15));
      5:       return 32'hFFFF_FFF0 | DATA_W'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // Bursty random traffic with a chosen operation mix
  task automatic drive_random(int items, int offer_pct, int poll_pct);
    int               gap;
    int               r;
    logic [OP_W-1:0]  op;
    for (int j = 0; j < items; j++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          gap        = 0;
          burst_left = $urandom_range(40, 80);
        end else begin
          gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          burst_left = $urandom_range(1, 24);
        end
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_SPARE;
      else if (r < 3 + offer_pct) op = OP_OFFER;
      else if (r < 3 + offer_pct + poll_pct) op = OP_POLL;
      else op = OP_PEEK;
      present(op, pick_key());
    end
  endtask

  // Main sequence
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_data  = '0;
    in_valid  = 1'b0;
    operation = OP_OFFER;
    key       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(CAPACITY_RESET, 1'b0);

    // directed: empty cases, spare code, key extremes, ties
    present(OP_PEEK,  32'h0000_0000);
    present(OP_POLL,  32'hFFFF_FFFF);
    present(OP_SPARE, 32'h1234_5678);
    present(OP_OFFER, 32'h8000_0000);
    present(OP_OFFER, 32'hFFFF_FFFF);
    present(OP_OFFER, 32'h0000_0000);
    present(OP_OFFER, 32'h0000_0000);
    present(OP_OFFER, 32'h0000_0005);
    present(OP_OFFER, 32'h0000_0005);
    present(OP_OFFER, 32'h5555_5555);
    present(OP_OFFER, 32'hAAAA_AAAA);
    present(OP_PEEK,  32'hFFFF_FFFF);
    present(OP_SPARE, 32'h0000_0000);
    repeat (4) present(OP_POLL, 32'h0000_0000);
    present(OP_PEEK,  32'h0000_0000);
    present(OP_OFFER, 32'h0000_0001);

    // fill up under min-first
    drive_random(150, 60, 25);

    // ordering flipped with entries held
    settle();
    configure(7'd64, 1'b1);
    drive_random(100, 40, 40);

    // capacity below the count: offers refused until drained
    settle();
    configure(7'd3, 1'b1);
    drive_random(60, 30, 55);

    // capacity zero acts as one
    settle();
    configure(7'd0, 1'b0);
    drive_random(40, 45, 40);

    // capacity past the store saturates; long output hold-off fills the block
    settle();
    configure(7'd127, 1'b0);
    squeeze_req = 1'b1;
    drive_random(160, 75, 15);

    // random setting, mostly draining
    settle();
    configure(CFG_DATA_W'($urandom_range(1, 64)), 1'($urandom));
    drive_random(140, 25, 60);

    // drain, then allow for any stray reply
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.faults == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
design/bhpq_pkg.sv
design/bhpq_engine.sv
design/binary_heap_priority_queue.sv
tb/binary_heap_priority_queue_tb.sv
